// ----- rtl/core/arpc_pkg.sv -----
// shared types and constants for the arp cache and responder
`timescale 1ns / 1ps
package arpc_pkg;
  localparam int CACHE_ENTRIES = 16;
  localparam int IDX_W = $clog2(CACHE_ENTRIES);
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

  localparam logic [15:0] OP_REQUEST = 16'd1;
  localparam logic [15:0] OP_REPLY = 16'd2;

  typedef enum logic [2:0] {
    ACT_ABSORB  = 3'd0,
    ACT_DELIVER = 3'd1,
    ACT_REPLY   = 3'd2,
    ACT_REQUEST = 3'd3,
    ACT_FORWARD = 3'd4,
    ACT_DROP    = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    CFG_OWN_IP   = 3'd0,
    CFG_OWN_MAC  = 3'd1,
    CFG_PIP_A    = 3'd2,
    CFG_PMAC_A   = 3'd3,
    CFG_PIP_B    = 3'd4,
    CFG_PMAC_B   = 3'd5,
    CFG_PROXY_EN = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DECIDE,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input beat, clear walk index
    logic rd;       // issue memory read at walk index
    logic cmp;      // evaluate compare on read data
    logic step;     // advance walk index
    logic decide;   // perform final update and build result
    logic out_take; // result consumed
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_done; // index reached entry count or send skips lookup
    logic hit;       // compare found a matching entry
  } stat_t;
endpackage

// ----- rtl/core/arpc_ctrl.sv -----
// sequencing state machine for the cache walk
`timescale 1ns / 1ps
module arpc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  arpc_pkg::stat_t st,
  output arpc_pkg::ctrl_t ctl
);
  arpc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= arpc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      arpc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          state_nxt = arpc_pkg::ST_READ;
        end
      end
      arpc_pkg::ST_READ: begin
        if (st.walk_done) begin
          state_nxt = arpc_pkg::ST_DECIDE;
        end else begin
          ctl.rd = 1'b1;
          state_nxt = arpc_pkg::ST_CMP;
        end
      end
      arpc_pkg::ST_CMP: begin
        ctl.cmp = 1'b1;
        if (st.hit) begin
          state_nxt = arpc_pkg::ST_DECIDE;
        end else begin
          ctl.step = 1'b1;
          state_nxt = arpc_pkg::ST_READ;
        end
      end
      arpc_pkg::ST_DECIDE: begin
        ctl.decide = 1'b1;
        state_nxt = arpc_pkg::ST_OUT;
      end
      arpc_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          ctl.out_take = 1'b1;
          state_nxt = arpc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = arpc_pkg::ST_IDLE;
    endcase
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input taken while a result waits");
  a_decide_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.decide |=> out_valid)
    else $error("decision without result");
endmodule

// ----- rtl/core/arpc_dp.sv -----
// datapath: config registers, cache memory, walk compare and result build
`timescale 1ns / 1ps
module arpc_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [47:0]     cfg_data,
  input  logic [177:0]    in_beat,
  output logic [263:0]    out_beat,
  input  arpc_pkg::ctrl_t ctl,
  output arpc_pkg::stat_t st
);
  localparam int IW = arpc_pkg::IDX_W;
  localparam int CW = arpc_pkg::CNT_W;

  logic [31:0] own_ip_r, pip_a_r, pip_b_r;
  logic [47:0] own_mac_r, pmac_a_r, pmac_b_r;
  logic [1:0]  pen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r <= '0; own_mac_r <= '0; pip_a_r <= '0; pmac_a_r <= '0;
      pip_b_r <= '0; pmac_b_r <= '0; pen_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        arpc_pkg::CFG_OWN_IP:   own_ip_r <= cfg_data[31:0];
        arpc_pkg::CFG_OWN_MAC:  own_mac_r <= cfg_data;
        arpc_pkg::CFG_PIP_A:    pip_a_r <= cfg_data[31:0];
        arpc_pkg::CFG_PMAC_A:   pmac_a_r <= cfg_data;
        arpc_pkg::CFG_PIP_B:    pip_b_r <= cfg_data[31:0];
        arpc_pkg::CFG_PMAC_B:   pmac_b_r <= cfg_data;
        arpc_pkg::CFG_PROXY_EN: pen_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // captured input beat
  logic        op_r, ipt_r;
  logic [15:0] opc_r;
  logic [31:0] sip_r, tip_r;
  logic [47:0] smac_r, hint_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_r <= in_beat[0];
      opc_r <= in_beat[16:1];
      sip_r <= in_beat[48:17];
      smac_r <= in_beat[96:49];
      tip_r <= in_beat[128:97];
      hint_r <= in_beat[176:129];
      ipt_r <= in_beat[177];
    end
  end

  // cache memory
  logic [31:0] mem_ip [arpc_pkg::CACHE_ENTRIES];
  logic [47:0] mem_mac [arpc_pkg::CACHE_ENTRIES];
  logic        mem_cpl [arpc_pkg::CACHE_ENTRIES];
  logic [31:0] rd_ip_r;
  logic [47:0] rd_mac_r;
  logic        rd_cpl_r;

  logic [CW-1:0] cnt_r, idx_r;
  logic          found_r, same_ip_r, hit_cpl_r;
  logic [47:0]   hit_mac_r;
  logic [IW-1:0] hit_idx_r;

  logic cmp_ip, cmp_mac, cmp_hit;
  assign cmp_ip = (rd_ip_r == (op_r ? tip_r : sip_r));
  assign cmp_mac = op_r && (rd_mac_r == hint_r);
  assign cmp_hit = cmp_ip || cmp_mac;
  assign st.hit = cmp_hit;
  // a send to own ip skips the lookup
  assign st.walk_done = (idx_r == cnt_r) || (op_r && tip_r == own_ip_r);

  // decision logic
  logic full;
  logic [47:0] cur_dst_r, cur_src_r, held_r;
  logic        wr_en;
  logic [IW-1:0] wr_idx;
  logic [31:0] wr_ip;
  logic [47:0] wr_mac;
  logic        wr_cpl;
  logic        append;
  logic        pa, pb, is_reply;
  logic [47:0] rep_mac;
  logic [31:0] rep_ip;
  logic        send_use;

  assign full = (cnt_r == CW'(arpc_pkg::CACHE_ENTRIES));
  assign pa = pen_r[0] && (pip_a_r == tip_r);
  assign pb = pen_r[1] && (pip_b_r == tip_r);
  assign is_reply = pa || pb || (tip_r == own_ip_r);
  assign rep_mac = pa ? pmac_a_r : (pb ? pmac_b_r : own_mac_r);
  assign rep_ip = pa ? pip_a_r : (pb ? pip_b_r : own_ip_r);
  assign send_use = found_r && hit_cpl_r;

  always_comb begin
    append = 1'b0;
    wr_en = 1'b0;
    wr_idx = hit_idx_r;
    wr_ip = sip_r;
    wr_mac = smac_r;
    wr_cpl = 1'b1;
    if (!op_r) begin
      if (found_r) begin
        wr_en = 1'b1;
      end else if (sip_r != own_ip_r && opc_r == arpc_pkg::OP_REQUEST) begin
        append = 1'b1;
      end
    end else if (!send_use && !same_ip_r) begin
      append = 1'b1;
      wr_ip = tip_r;
      wr_mac = '0;
      wr_cpl = 1'b0;
    end
    // new entries go right after the last appended one
    if (append && !full) begin
      wr_en = 1'b1;
      wr_idx = cnt_r[IW-1:0];
    end
  end

  logic [2:0]  o_act;
  logic [47:0] o_dst, o_src, o_smac, o_tmac;
  logic [1:0]  o_opc;
  logic [31:0] o_sip, o_tip;
  logic        o_full;
  logic [47:0] dst_nxt, held_nxt, src_nxt;

  always_comb begin
    dst_nxt = cur_dst_r;
    src_nxt = cur_src_r;
    held_nxt = held_r;
    o_act = arpc_pkg::ACT_DROP;
    o_opc = 2'd0;
    o_smac = '0; o_sip = '0; o_tmac = '0; o_tip = '0;
    o_full = append && full;
    if (!op_r) begin
      if (sip_r == own_ip_r) begin
        o_act = arpc_pkg::ACT_ABSORB;
      end else if (opc_r == arpc_pkg::OP_REPLY) begin
        o_act = arpc_pkg::ACT_DELIVER;
      end else if (is_reply) begin
        dst_nxt = smac_r;
        held_nxt = smac_r;
        src_nxt = rep_mac;
        o_act = arpc_pkg::ACT_REPLY;
        o_opc = 2'd2;
        o_smac = rep_mac; o_sip = rep_ip; o_tmac = smac_r; o_tip = sip_r;
      end
    end else begin
      if (send_use) begin
        dst_nxt = hit_mac_r;
        held_nxt = hit_mac_r;
      end else if (!same_ip_r) begin
        dst_nxt = arpc_pkg::BCAST_MAC;
        held_nxt = '0;
      end
      if (ipt_r) begin
        o_act = arpc_pkg::ACT_FORWARD;
      end else begin
        o_act = arpc_pkg::ACT_REQUEST;
        o_opc = 2'd1;
        o_smac = own_mac_r; o_sip = own_ip_r; o_tmac = held_nxt; o_tip = tip_r;
      end
    end
    o_dst = dst_nxt;
    o_src = src_nxt;
    if (!op_r && sip_r == own_ip_r) begin
      o_dst = '0; o_src = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_ip_r <= mem_ip[idx_r[IW-1:0]];
      rd_mac_r <= mem_mac[idx_r[IW-1:0]];
      rd_cpl_r <= mem_cpl[idx_r[IW-1:0]];
    end
    if (wr_en && ctl.decide) begin
      mem_ip[wr_idx] <= wr_ip;
      mem_mac[wr_idx] <= wr_mac;
      mem_cpl[wr_idx] <= wr_cpl;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp && cmp_hit) begin
      hit_idx_r <= idx_r[IW-1:0];
      hit_mac_r <= rd_mac_r;
      hit_cpl_r <= rd_cpl_r;
      same_ip_r <= cmp_ip;
    end else if (ctl.load) begin
      same_ip_r <= 1'b0;
    end
    if (ctl.decide) begin
      out_beat <= {2'd0, o_full, o_tip, o_tmac, o_sip, o_smac, o_opc,
                   o_src, o_dst, o_act};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; idx_r <= '0; found_r <= 1'b0;
      cur_dst_r <= '0; cur_src_r <= '0; held_r <= '0;
    end else begin
      if (ctl.load) begin
        idx_r <= '0;
        found_r <= 1'b0;
      end else if (ctl.step) begin
        idx_r <= idx_r + CW'(1);
      end
      if (ctl.cmp && cmp_hit) found_r <= 1'b1;
      if (ctl.decide) begin
        cur_dst_r <= dst_nxt;
        cur_src_r <= src_nxt;
        held_r <= held_nxt;
        if (append && !full) cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(arpc_pkg::CACHE_ENTRIES))
    else $error("entry count overflow");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rd |-> idx_r < cnt_r)
    else $error("read beyond written entries");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.decide |=> cnt_r == $past(cnt_r))
    else $error("count changed outside decision");
endmodule

// ----- rtl/core/arp_cache_and_responder.sv -----
// top level of the arp cache and responder
//
// one input beat is either a received arp packet or a send request; each
// beat yields exactly one result beat. in_tvalid/in_tready take an item,
// out_tvalid/out_tready deliver its result. configuration is written on
// cfg_we/cfg_index/cfg_data while the block is idle; the user must keep
// to that, the block itself does not enforce it.
// an item walks the cache one entry at a time (memory read, then
// compare), stopping at the first match.
// one item is in work at a time; a new beat is taken after the result is
// taken. while out_tready is low the result holds and no input is taken.
// reset empties the cache (entry count zero), clears the configuration
// and the current addresses; no clearing pass is needed.
`timescale 1ns / 1ps
module arp_cache_and_responder (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [47:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // operation, arp_opcode, sender_ip, sender_mac, target_ip,
  // target_mac_hint, is_ip_traffic, zero pad
  input  logic [183:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // action, eth_dst_mac, eth_src_mac, out_opcode, out_sender_mac,
  // out_sender_ip, out_target_mac, out_target_ip, cache_full, zero pad
  output logic [263:0] out_tdata
);
  arpc_pkg::ctrl_t ctl;
  arpc_pkg::stat_t st;
  logic [263:0] beat;

  arpc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .st(st), .ctl(ctl)
  );

  arpc_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_beat(in_tdata[177:0]), .out_beat(beat),
    .ctl(ctl), .st(st)
  );

  assign out_tdata = beat;
endmodule

// ----- tb/tb_arp_cache_and_responder.sv -----
// self-checking testbench for the arp cache and responder
`timescale 1ns / 1ps
module tb_arp_cache_and_responder;
  localparam logic OPER_RECV = 1'b0;
  localparam logic OPER_SEND = 1'b1;
  localparam logic [2:0] CFG_NONE = 3'd7;  // index past the last register
  localparam int IDLE_TAIL = 45;
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic        is_ip;
    logic [47:0] hint;
    logic [31:0] tip;
    logic [47:0] smac;
    logic [31:0] sip;
    logic [15:0] opc;
    logic        oper;
  } arp_item_t;

  typedef struct packed {
    logic        full;
    logic [31:0] tip;
    logic [47:0] tmac;
    logic [31:0] sip;
    logic [47:0] smac;
    logic [1:0]  opc;
    logic [47:0] src;
    logic [47:0] dst;
    arpc_pkg::action_t act;
  } arp_res_t;

  logic clk = 1'b0, rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = arpc_pkg::CFG_OWN_IP;
  logic [47:0] cfg_data = '0;
  logic in_tvalid = 1'b0, in_tready;
  logic [183:0] in_tdata = '0;
  logic out_tvalid, out_tready = 1'b0;
  logic [263:0] out_tdata;

  arp_cache_and_responder u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [31:0] own_ip, pip_a, pip_b;
  logic [47:0] own_mac, pmac_a, pmac_b;
  logic [1:0]  proxy_en;
  logic [31:0] c_ip [arpc_pkg::CACHE_ENTRIES];
  logic [47:0] c_mac [arpc_pkg::CACHE_ENTRIES];
  logic        c_done [arpc_pkg::CACHE_ENTRIES];
  int          c_cnt;
  logic [47:0] cur_dst, cur_src, held_tmac;

  arp_res_t pending_results[$];
  int errors = 0;
  bit quiet = 1'b0;
  bit in_hit = 1'b0, out_hit = 1'b0;
  logic [263:0] out_snap;
  int stall_cnt = 0;
  logic [31:0] ip_pool [8];
  logic [47:0] mac_pool [4];

  function automatic bit cache_append(logic [31:0] ip, logic [47:0] mac, logic done);
    if (c_cnt >= arpc_pkg::CACHE_ENTRIES) return 1'b1;
    c_ip[c_cnt] = ip;
    c_mac[c_cnt] = mac;
    c_done[c_cnt] = done;
    c_cnt++;
    return 1'b0;
  endfunction

  function automatic arp_res_t resolve(arp_item_t it);
    arp_res_t r;
    bit found, full, proxy, same_ip, same_mac;
    logic [47:0] rmac;
    logic [31:0] rip;
    int hit;
    r = '0;
    found = 0; full = 0; proxy = 0; same_ip = 0; same_mac = 0; hit = 0;
    rmac = '0; rip = '0;
    if (it.oper == OPER_RECV) begin
      for (int i = 0; i < c_cnt; i++) begin
        if (c_ip[i] == it.sip) begin
          c_mac[i] = it.smac;
          c_done[i] = 1'b1;
          found = 1;
          break;
        end
      end
      if (it.sip == own_ip) begin
        r.act = arpc_pkg::ACT_ABSORB;
        return r;
      end
      if (it.opc == arpc_pkg::OP_REPLY) begin
        r.act = arpc_pkg::ACT_DELIVER; r.dst = cur_dst; r.src = cur_src;
        return r;
      end
      if (it.opc == arpc_pkg::OP_REQUEST && !found)
        full = cache_append(it.sip, it.smac, 1'b1);
      if (proxy_en[0] && pip_a == it.tip) begin
        proxy = 1; rmac = pmac_a; rip = pip_a;
      end else if (proxy_en[1] && pip_b == it.tip) begin
        proxy = 1; rmac = pmac_b; rip = pip_b;
      end
      if (!proxy) begin
        if (it.tip != own_ip) begin
          r.act = arpc_pkg::ACT_DROP; r.dst = cur_dst; r.src = cur_src; r.full = full;
          return r;
        end
        rmac = own_mac; rip = own_ip;
      end
      held_tmac = it.smac;
      cur_dst = it.smac;
      cur_src = rmac;
      r.act = arpc_pkg::ACT_REPLY; r.dst = cur_dst; r.src = cur_src;
      r.opc = arpc_pkg::OP_REPLY[1:0];
      r.smac = rmac; r.sip = rip; r.tmac = it.smac; r.tip = it.sip; r.full = full;
      return r;
    end
    if (it.tip != own_ip) begin
      for (int i = 0; i < c_cnt; i++) begin
        if (c_ip[i] == it.tip) begin
          same_ip = 1; hit = i; break;
        end
        if (c_mac[i] == it.hint) begin
          same_mac = 1; hit = i; break;
        end
      end
    end
    if ((same_ip || same_mac) && c_done[hit]) begin
      held_tmac = c_mac[hit];
      cur_dst = c_mac[hit];
    end else if (!same_ip) begin
      held_tmac = '0;
      cur_dst = arpc_pkg::BCAST_MAC;
      full = cache_append(it.tip, '0, 1'b0);
    end
    r.dst = cur_dst; r.src = cur_src; r.full = full;
    if (it.is_ip) r.act = arpc_pkg::ACT_FORWARD;
    else begin
      r.act = arpc_pkg::ACT_REQUEST; r.opc = arpc_pkg::OP_REQUEST[1:0]; r.smac = own_mac;
      r.sip = own_ip; r.tmac = held_tmac; r.tip = it.tip;
    end
    return r;
  endfunction

  // sampling at the falling edge keeps the checks free of edge races
  always @(negedge clk) begin
    in_hit = rst_n && in_tvalid && in_tready;
    out_hit = rst_n && out_tvalid && out_tready;
    out_snap = out_tdata;
  end

  always @(posedge clk) begin
    out_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 30);
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    arp_res_t exp_r, got_r;
    if (out_hit) begin
      got_r = out_snap[261:0];
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: %h", got_r);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("action", exp_r.act, got_r.act);
        check_field("eth_dst_mac", exp_r.dst, got_r.dst);
        check_field("eth_src_mac", exp_r.src, got_r.src);
        check_field("out_opcode", exp_r.opc, got_r.opc);
        check_field("out_sender_mac", exp_r.smac, got_r.smac);
        check_field("out_sender_ip", exp_r.sip, got_r.sip);
        check_field("out_target_mac", exp_r.tmac, got_r.tmac);
        check_field("out_target_ip", exp_r.tip, got_r.tip);
        check_field("cache_full", exp_r.full, got_r.full);
        check_field("pad", 0, out_snap[263:262]);
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (in_hit || out_hit) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(arp_item_t it);
    int gap;
    gap = quiet ? 0 : (($urandom_range(99) < 30) ? $urandom_range(1, 4) : 0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, it};
    do @(posedge clk); while (!in_hit);
    pending_results = {pending_results, resolve(it)};
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      arpc_pkg::CFG_OWN_IP:   own_ip = val[31:0];
      arpc_pkg::CFG_OWN_MAC:  own_mac = val;
      arpc_pkg::CFG_PIP_A:    pip_a = val[31:0];
      arpc_pkg::CFG_PMAC_A:   pmac_a = val;
      arpc_pkg::CFG_PIP_B:    pip_b = val[31:0];
      arpc_pkg::CFG_PMAC_B:   pmac_b = val;
      arpc_pkg::CFG_PROXY_EN: proxy_en = val[1:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [31:0] oip, logic [47:0] omac, logic [31:0] ia,
                           logic [47:0] ma, logic [31:0] ib, logic [47:0] mb,
                           logic [1:0] en);
    write_reg(arpc_pkg::CFG_OWN_IP, {16'h0, oip});
    write_reg(arpc_pkg::CFG_OWN_MAC, omac);
    write_reg(arpc_pkg::CFG_PIP_A, {16'h0, ia});
    write_reg(arpc_pkg::CFG_PMAC_A, ma);
    write_reg(arpc_pkg::CFG_PIP_B, {16'h0, ib});
    write_reg(arpc_pkg::CFG_PMAC_B, mb);
    write_reg(arpc_pkg::CFG_PROXY_EN, {46'h0, en});
    ip_pool[0] = oip; ip_pool[1] = ia; ip_pool[2] = ib;
    for (int i = 3; i < 8; i++) ip_pool[i] = 32'h0A00_0000 + i;
  endtask

  function automatic arp_item_t mk(logic oper, logic [15:0] opc, logic [31:0] sip,
                                   logic [47:0] smac, logic [31:0] tip,
                                   logic [47:0] hint, logic is_ip);
    arp_item_t it;
    it.oper = oper; it.opc = opc; it.sip = sip; it.smac = smac;
    it.tip = tip; it.hint = hint; it.is_ip = is_ip;
    return it;
  endfunction

  task automatic test_directed();
    configure(32'hC0A8_0001, 48'h0200_0000_0001, 32'hC0A8_0064, 48'h0200_0000_00AA,
              32'hC0A8_0065, 48'h0200_0000_00BB, 2'b11);
    write_reg(CFG_NONE, 48'hFFFF_FFFF_FFFF);  // must be ignored
    // request for own ip from a new sender, then the same sender again
    send_item(mk(OPER_RECV, arpc_pkg::OP_REQUEST, 32'hC0A8_0002, 48'h0200_0000_0002,
                 32'hC0A8_0001, 48'h0, 1'b0));
    send_item(mk(OPER_RECV, arpc_pkg::OP_REQUEST, 32'hC0A8_0002, 48'h0200_0000_0022,
                 32'hC0A8_0001, 48'h0, 1'b0));
    // proxy a then proxy b, and a request that is not for us
    send_item(mk(OPER_RECV, arpc_pkg::OP_REQUEST, 32'hC0A8_0003, 48'hFFFF_FFFF_FFFF,
                 32'hC0A8_0064, 48'h0, 1'b0));
    send_item(mk(OPER_RECV, arpc_pkg::OP_REQUEST, 32'hFFFF_FFFF, 48'h0, 32'hC0A8_0065,
                 48'h0, 1'b1));
    send_item(mk(OPER_RECV, arpc_pkg::OP_REQUEST, 32'h0, 48'h1, 32'h7F00_0001, 48'h0, 1'b0));
    // reply, own sender, odd opcodes
    send_item(mk(OPER_RECV, arpc_pkg::OP_REPLY, 32'hC0A8_0009, 48'h0200_0000_0009, 32'h0,
                 48'h0, 1'b0));
    send_item(mk(OPER_RECV, arpc_pkg::OP_REQUEST, 32'hC0A8_0001, 48'h0, 32'hC0A8_0001,
                 48'h0, 1'b0));
    send_item(mk(OPER_RECV, 16'hFFFF, 32'hC0A8_0010, 48'h5, 32'hC0A8_0001, 48'h0, 1'b0));
    send_item(mk(OPER_RECV, 16'h0000, 32'hC0A8_0011, 48'h6, 32'hC0A8_0002, 48'h0, 1'b0));
    // sends: complete hit, miss, incomplete hit, mac-only hit, gratuitous
    send_item(mk(OPER_SEND, 16'h0, 32'h0, 48'h0, 32'hC0A8_0002, 48'h0, 1'b1));
    send_item(mk(OPER_SEND, 16'hFFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hC0A8_0020,
                 48'hFFFF_FFFF_FFFE, 1'b0));
    send_item(mk(OPER_SEND, 16'h0, 32'h0, 48'h0, 32'hC0A8_0020, 48'h9, 1'b0));
    send_item(mk(OPER_SEND, 16'h0, 32'h0, 48'h0, 32'hC0A8_0030,
                 48'h0200_0000_0022, 1'b1));
    send_item(mk(OPER_SEND, 16'h0, 32'h0, 48'h0, 32'hC0A8_0031, 48'h0, 1'b0));
    send_item(mk(OPER_SEND, 16'h0, 32'h0, 48'h0, 32'hC0A8_0001, 48'h0, 1'b0));
    send_item(mk(OPER_RECV, arpc_pkg::OP_REPLY, 32'hC0A8_0020, 48'h0200_0000_0020, 32'h0,
                 48'h0, 1'b0));
    send_item(mk(OPER_SEND, 16'h0, 32'h0, 48'h0, 32'hC0A8_0020, 48'h0, 1'b0));
    // fill the cache past its end
    for (int i = 0; i < arpc_pkg::CACHE_ENTRIES - 3; i++)
      send_item(mk(OPER_SEND, 16'h0, 32'h0, 48'h0, 32'hAC10_0000 + i, 48'h7, 1'b1));
    drain();
  endtask

  function automatic logic [31:0] pick_ip();
    return ($urandom_range(9) == 0) ? $urandom() : ip_pool[$urandom_range(7)];
  endfunction

  function automatic logic [47:0] pick_mac();
    if ($urandom_range(9) == 0) return 48'({$urandom(), $urandom()});
    return mac_pool[$urandom_range(3)];
  endfunction

  task automatic test_random(int n);
    arp_item_t it;
    for (int k = 0; k < n; k++) begin
      quiet = (k >= n / 3) && (k < n / 2);
      it.oper = 1'($urandom_range(1));
      case ($urandom_range(9))
        0: it.opc = 16'($urandom());
        1, 2, 3, 4: it.opc = arpc_pkg::OP_REPLY;
        default: it.opc = arpc_pkg::OP_REQUEST;
      endcase
      it.sip = pick_ip();
      it.smac = pick_mac();
      it.tip = pick_ip();
      it.hint = pick_mac();
      it.is_ip = 1'($urandom_range(1));
      send_item(it);
      // let everything settle once in a while
      if ($urandom_range(199) == 0) drain();
    end
    quiet = 1'b0;
    drain();
  endtask

  initial begin
    own_ip = '0; own_mac = '0; pip_a = '0; pmac_a = '0; pip_b = '0; pmac_b = '0;
    proxy_en = '0; c_cnt = 0; cur_dst = '0; cur_src = '0; held_tmac = '0;
    for (int i = 0; i < 8; i++) ip_pool[i] = '0;
    mac_pool[0] = 48'h0; mac_pool[1] = 48'hFFFF_FFFF_FFFF;
    mac_pool[2] = 48'h0200_0000_0002; mac_pool[3] = 48'h0200_0000_0022;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // defaults straight out of reset: everything zero
    send_item(mk(OPER_RECV, arpc_pkg::OP_REQUEST, 32'h5, 48'h5, 32'h0, 48'h0, 1'b0));
    send_item(mk(OPER_SEND, 16'h0, 32'h0, 48'h0, 32'h0, 48'h0, 1'b0));
    drain();
    test_directed();
    test_random(600);
    configure(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
              32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 2'b11);
    test_random(400);
    configure($urandom(), 48'({$urandom(), $urandom()}), 32'h0A00_0005,
              48'({$urandom(), $urandom()}), 32'h0A00_0005,
              48'({$urandom(), $urandom()}), 2'b10);
    test_random(400);
    configure(32'h0, 48'h0, 32'h0A00_0003, 48'h0, 32'h0A00_0004, 48'hFFFF_FFFF_FFFF, 2'b01);
    test_random(600);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/core/arpc_pkg.sv
rtl/core/arpc_ctrl.sv
rtl/core/arpc_dp.sv
rtl/core/arp_cache_and_responder.sv
tb/tb_arp_cache_and_responder.sv
